>>> hdl/icmp_echo_rtt_tracker_macros.svh
// Assertion macros for the ICMP echo RTT tracker
`ifndef ICMP_ECHO_RTT_TRACKER_MACROS_SVH
`define ICMP_ECHO_RTT_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define ERT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ert: assertion failed");
`define ERT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ert: assertion failed");
`else
`define ERT_ASSERT(lbl, prop)
`define ERT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> hdl/ert_pkg.sv
// Shared constants and controller/datapath types for the echo RTT tracker
`default_nettype none
package ert_pkg;
  localparam int DEPTH_DEF  = 256;
  localparam int TS_W       = 48;
  localparam int RTT_W      = 49;
  localparam int CNT_W      = 9;
  localparam int LOSS_W     = 14;
  localparam int LOSS_SCALE = 10000;
  localparam int IN_DW      = 152;
  localparam int OUT_DW     = 200;
  localparam int KEY_W      = 96;

  localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;
  localparam logic [7:0] ICMP_ECHO_REP = 8'd0;

  typedef logic [1:0] status_t;
  localparam status_t ST_RECORDED = 2'd0;
  localparam status_t ST_IGNORED  = 2'd1;
  localparam status_t ST_DROPPED  = 2'd2;
  localparam status_t ST_SUMMARY  = 2'd3;

  typedef struct packed {
    logic    cap;
    logic    clr_idx;
    logic    rd;
    logic    inc_idx;
    logic    upd;
    logic    app;
    logic    acc_clr;
    logic    acc;
    logic    div_start;
    logic    div_sel;
    logic    div_cap;
    logic    ld_out;
    status_t st;
  } cmd_t;

  typedef struct packed {
    logic is_sum;
    logic is_echo;
    logic scan_end;
    logic full;
    logic match;
    logic div_done;
    logic comp_zero;
    logic req_zero;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

>>> hdl/ert_div.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none
module ert_div #(
  parameter int DW = 58,
  parameter int VW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quot
);
  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] rem_r, rem_nxt, dv_r;
  logic [NW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [VW:0]   trial;
  logic          ge;

  always_comb begin
    trial   = {rem_r, q_r[DW-1]};
    ge      = trial >= {1'b0, dv_r};
    rem_nxt = ge ? VW'(trial - {1'b0, dv_r}) : trial[VW-1:0];
    q_nxt   = {q_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= NW'(DW);
        q_r    <= dividend;
        rem_r  <= '0;
        dv_r   <= divisor;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

>>> hdl/ert_ctrl.sv
// Sequencer for lookup, append, summary walk and the two divisions
`default_nettype none
module ert_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire ert_pkg::sts_t sts,
  output ert_pkg::cmd_t      cmd
);
  import ert_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_LOOK, S_CMP, S_SLOOK, S_SACC,
    S_AVG, S_AVGW, S_LOSS, S_LOSSW, S_OUT
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  always_comb begin
    cmd       = '0;
    cmd.st    = st_r;
    state_nxt = state_r;
    st_nxt    = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_sum) begin
          cmd.clr_idx = 1'b1;
          cmd.acc_clr = 1'b1;
          st_nxt      = ST_SUMMARY;
          state_nxt   = S_SLOOK;
        end else if (!sts.is_echo) begin
          st_nxt    = ST_IGNORED;
          state_nxt = S_OUT;
        end else begin
          cmd.clr_idx = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.scan_end) begin
          if (sts.full) begin
            st_nxt = ST_DROPPED;
          end else begin
            cmd.app = 1'b1;
            st_nxt  = ST_RECORDED;
          end
          state_nxt = S_OUT;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.upd   = 1'b1;
          st_nxt    = ST_RECORDED;
          state_nxt = S_OUT;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_SLOOK: begin
        if (sts.scan_end) begin
          state_nxt = S_AVG;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SACC;
        end
      end
      S_SACC: begin
        cmd.acc     = 1'b1;
        cmd.inc_idx = 1'b1;
        state_nxt   = S_SLOOK;
      end
      S_AVG: begin
        if (sts.comp_zero) begin
          state_nxt = S_LOSS;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_AVGW;
        end
      end
      S_AVGW: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = S_LOSS;
        end
      end
      S_LOSS: begin
        cmd.div_sel = 1'b1;
        if (sts.req_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_LOSSW;
        end
      end
      S_LOSSW: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_RECORDED;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);
endmodule
`default_nettype wire

>>> hdl/ert_dp.sv
// Datapath: exchange table, scan index, summary accumulators, result register
`default_nettype none
`include "icmp_echo_rtt_tracker_macros.svh"
module ert_dp #(
  parameter int TABLE_DEPTH = ert_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [ert_pkg::IN_DW-1:0]    in_tdata,
  input  wire logic                         in_tuser,
  output logic [ert_pkg::OUT_DW-1:0]        out_tdata,
  output logic [1:0]                        out_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  input  wire ert_pkg::cmd_t                cmd,
  output ert_pkg::sts_t                     sts
);
  import ert_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = RTT_W + AW + 1;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [1:0]       flag_mem[TABLE_DEPTH];
  logic [TS_W-1:0]  rq_mem  [TABLE_DEPTH];
  logic [TS_W-1:0]  rp_mem  [TABLE_DEPTH];

  logic              sumreq_r, echo_r, isreq_r;
  logic [KEY_W-1:0]  key_r, rk_r;
  logic [TS_W-1:0]   ts_r, rq_r, rp_r;
  logic [1:0]        rf_r;
  logic [CW-1:0]     idx_r, fill_r;
  logic [CW-1:0]     nreq_r, nrep_r, nmiss_r, ncomp_r;
  logic signed [RTT_W-1:0] min_r, max_r, avg_r;
  logic signed [SW-1:0]    sum_r;
  logic [LOSS_W-1:0] loss_r;
  logic [OUT_DW-1:0] out_data_r;
  logic [1:0]        out_user_r;
  logic              out_valid_r;

  logic [7:0]        in_type;
  logic [31:0]       in_src, in_dst;
  logic              in_isreq;
  logic [AW-1:0]     wa, ra;
  logic [1:0]        side, flag_w;
  logic signed [RTT_W-1:0] rtt;
  logic              has_req, has_rep;
  logic [SW-1:0]     sum_mag, dividend, quot;
  logic [CW-1:0]     divisor;
  logic [CW+13:0]    lprod;
  logic [RTT_W-1:0]  qs;
  logic              div_done;

  function automatic logic [CNT_W-1:0] cnt9(input logic [CW-1:0] c);
    logic [CW+CNT_W-1:0] e;
    e = {{CNT_W{1'b0}}, c};
    return e[CNT_W-1:0];
  endfunction

  assign in_type  = in_tdata[7:0];
  assign in_src   = in_tdata[39:8];
  assign in_dst   = in_tdata[71:40];
  assign in_isreq = (in_type == ICMP_ECHO_REQ);

  assign wa     = cmd.app ? fill_r[AW-1:0] : idx_r[AW-1:0];
  assign ra     = idx_r[AW-1:0];
  assign side   = isreq_r ? 2'b01 : 2'b10;
  assign flag_w = cmd.app ? side : (rf_r | side);

  assign rtt     = signed'({1'b0, rp_r}) - signed'({1'b0, rq_r});
  assign has_req = rf_r[0];
  assign has_rep = rf_r[1];

  assign sum_mag  = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign lprod    = nmiss_r * 14'(LOSS_SCALE);
  assign dividend = cmd.div_sel ? SW'(lprod) : sum_mag;
  assign divisor  = cmd.div_sel ? nreq_r : ncomp_r;
  assign qs       = quot[RTT_W-1:0];

  ert_div #(.DW(SW), .VW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (quot)
  );

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.app) key_mem[wa] <= key_r;
    if (cmd.app || cmd.upd) flag_mem[wa] <= flag_w;
    if (cmd.app || (cmd.upd && isreq_r)) rq_mem[wa] <= isreq_r ? ts_r : '0;
    if (cmd.app || (cmd.upd && !isreq_r)) rp_mem[wa] <= isreq_r ? '0 : ts_r;
    if (cmd.rd) begin
      rk_r <= key_mem[ra];
      rf_r <= flag_mem[ra];
      rq_r <= rq_mem[ra];
      rp_r <= rp_mem[ra];
    end
  end

  // request capture; a reply swaps source and destination
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      sumreq_r <= in_tuser;
      echo_r   <= in_isreq || (in_type == ICMP_ECHO_REP);
      isreq_r  <= in_isreq;
      key_r    <= {in_isreq ? in_src : in_dst, in_isreq ? in_dst : in_src,
                   in_tdata[87:72], in_tdata[103:88]};
      ts_r     <= in_tdata[151:104];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.app) fill_r <= fill_r + 1'b1;
      if (cmd.clr_idx) idx_r <= '0;
      else if (cmd.inc_idx) idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      nreq_r  <= '0;
      nrep_r  <= '0;
      nmiss_r <= '0;
      ncomp_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      sum_r   <= '0;
      avg_r   <= '0;
      loss_r  <= '0;
    end else begin
      if (cmd.acc) begin
        if (has_req) nreq_r <= nreq_r + 1'b1;
        if (has_rep) nrep_r <= nrep_r + 1'b1;
        if (has_req && !has_rep) nmiss_r <= nmiss_r + 1'b1;
        if (has_req && has_rep) begin
          ncomp_r <= ncomp_r + 1'b1;
          sum_r   <= sum_r + SW'(rtt);
          if (ncomp_r == '0 || rtt < min_r) min_r <= rtt;
          if (ncomp_r == '0 || rtt > max_r) max_r <= rtt;
        end
      end
      if (cmd.div_cap) begin
        if (cmd.div_sel) loss_r <= quot[LOSS_W-1:0];
        else avg_r <= sum_r[SW-1] ? RTT_W'(-qs) : qs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_user_r <= cmd.st;
      if (cmd.st == ST_SUMMARY) begin
        out_data_r <= {2'b00, loss_r, avg_r, max_r, min_r, (ncomp_r != '0),
                       cnt9(ncomp_r), cnt9(nmiss_r), cnt9(nrep_r), cnt9(nreq_r)};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign sts.is_sum    = sumreq_r;
  assign sts.is_echo   = echo_r;
  assign sts.scan_end  = (idx_r == fill_r);
  assign sts.full      = (fill_r == CW'(TABLE_DEPTH));
  assign sts.match     = (rk_r == key_r);
  assign sts.div_done  = div_done;
  assign sts.comp_zero = (ncomp_r == '0);
  assign sts.req_zero  = (nreq_r == '0);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  `ERT_ASSERT(a_fill_bound, fill_r <= CW'(TABLE_DEPTH))
  `ERT_ASSERT(a_no_append_full, cmd.app |-> !sts.full)
  `ERT_ASSERT(a_append_grows, cmd.app |=> fill_r == $past(fill_r) + 1'b1)
endmodule
`default_nettype wire

>>> hdl/icmp_echo_rtt_tracker.sv
// ICMP echo round-trip tracker, top level
// Input stream (in_*): one request per item. in_tuser selects an echo packet
// (0) or a summary (1); in_tdata carries the packet fields.
// Output stream (out_*): exactly one result per request; out_tuser is the
// status, out_tdata the summary fields (all zero for a packet request).
// A packet's key is looked up by a linear scan over the filled entries
// (read then compare on the single table read port); a non-echo type skips
// the scan.
// A summary walks the table, then makes up to two passes of the shared
// one-bit-per-cycle divider, whose dividend width is 50 + ceil(log2(depth)).
// One request is worked on at a time; in_tready is high only while idle,
// from the cycle after the result is loaded.
// A finished result sits in the output register, so the next request is
// taken while out_tvalid waits; it is then held before loading the result.
// Reset empties the table (fill count to zero); no clearing pass is needed.
// Once TABLE_DEPTH entries are filled, new keys are dropped with status 2.
`default_nettype none
module icmp_echo_rtt_tracker #(
  parameter int TABLE_DEPTH = ert_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // icmp_type[7:0], source_ip[39:8], dest_ip[71:40], echo_ident[87:72],
  // echo_seq[103:88], capture_time_us[151:104]
  input  wire logic [ert_pkg::IN_DW-1:0]  in_tdata,
  // req_type[0]
  input  wire logic                       in_tuser,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // request_total[8:0], reply_total[17:9], missing_total[26:18],
  // complete_total[35:27], rtt_valid[36], rtt_min_us[85:37],
  // rtt_max_us[134:86], rtt_avg_us[183:135], loss_bp[197:184], zero pad
  output logic [ert_pkg::OUT_DW-1:0]      out_tdata,
  // status[1:0]
  output logic [1:0]                      out_tuser
);
  import ert_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ert_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ert_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );
endmodule
`default_nettype wire

>>> test/tb.sv
// Testbench for the ICMP echo RTT tracker: directed and random echo traffic checked against a table model
`default_nettype none
module tb;
  import ert_pkg::*;

  localparam int DEPTH = 256;

  typedef struct packed {
    logic [1:0]        st;
    logic [CNT_W-1:0]  n_req;
    logic [CNT_W-1:0]  n_rep;
    logic [CNT_W-1:0]  n_miss;
    logic [CNT_W-1:0]  n_comp;
    logic              rtt_ok;
    logic [RTT_W-1:0]  rtt_min;
    logic [RTT_W-1:0]  rtt_max;
    logic [RTT_W-1:0]  rtt_avg;
    logic [LOSS_W-1:0] loss;
  } echo_res_t;

  int errors = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  class echo_table_sb;
    logic [31:0] reqr_q[DEPTH];
    logic [31:0] resp_q[DEPTH];
    logic [15:0] id_q[DEPTH];
    logic [15:0] seq_q[DEPTH];
    logic [1:0]  side_q[DEPTH];
    logic [47:0] t_req[DEPTH];
    logic [47:0] t_rep[DEPTH];
    int          fill;
    echo_res_t   pending[$];
    int          n_checked;

    function new();
      fill = 0;
      n_checked = 0;
    endfunction

    function echo_res_t summary();
      echo_res_t r;
      longint mn, mx, rtt, avg;
      longint unsigned pos, neg, loss;
      int nreq, nrep, nmiss, ncomp;
      r = '0;
      mn = 0; mx = 0; avg = 0; pos = 0; neg = 0; loss = 0;
      nreq = 0; nrep = 0; nmiss = 0; ncomp = 0;
      for (int i = 0; i < fill; i++) begin
        if (side_q[i][0]) nreq++;
        if (side_q[i][1]) nrep++;
        if (side_q[i] == 2'b01) nmiss++;
        if (side_q[i] == 2'b11) begin
          rtt = longint'({16'd0, t_rep[i]}) - longint'({16'd0, t_req[i]});
          ncomp++;
          if (rtt >= 0) pos += rtt; else neg += -rtt;
          if (ncomp == 1) begin
            mn = rtt; mx = rtt;
          end else begin
            if (rtt < mn) mn = rtt;
            if (rtt > mx) mx = rtt;
          end
        end
      end
      if (ncomp > 0) begin
        if (pos >= neg) avg = (pos - neg) / ncomp;
        else avg = -longint'((neg - pos) / ncomp);
      end
      if (nreq > 0) loss = (longint'(nmiss) * LOSS_SCALE) / nreq;
      r.st = ST_SUMMARY;
      r.n_req = CNT_W'(nreq); r.n_rep = CNT_W'(nrep);
      r.n_miss = CNT_W'(nmiss); r.n_comp = CNT_W'(ncomp);
      r.rtt_ok = ncomp > 0;
      r.rtt_min = mn[RTT_W-1:0]; r.rtt_max = mx[RTT_W-1:0]; r.rtt_avg = avg[RTT_W-1:0];
      r.loss = loss[LOSS_W-1:0];
      return r;
    endfunction

    function void note_request(input logic kind, input logic [IN_DW-1:0] d);
      echo_res_t r;
      logic [7:0] ty;
      logic [31:0] rq, rs;
      logic [15:0] id, sq;
      logic [47:0] ts;
      int i;
      r = '0;
      ty = d[7:0]; id = d[87:72]; sq = d[103:88]; ts = d[151:104];
      if (kind) r = summary();
      else if (ty != ICMP_ECHO_REQ && ty != ICMP_ECHO_REP) r.st = ST_IGNORED;
      else begin
        // replies are keyed from the requester's side
        rq = (ty == ICMP_ECHO_REQ) ? d[39:8] : d[71:40];
        rs = (ty == ICMP_ECHO_REQ) ? d[71:40] : d[39:8];
        for (i = 0; i < fill; i++)
          if (reqr_q[i] == rq && resp_q[i] == rs && id_q[i] == id && seq_q[i] == sq) break;
        if (i >= fill && fill >= DEPTH) r.st = ST_DROPPED;
        else begin
          if (i >= fill) begin
            reqr_q[i] = rq; resp_q[i] = rs; id_q[i] = id; seq_q[i] = sq;
            side_q[i] = '0; t_req[i] = '0; t_rep[i] = '0;
            fill++;
          end
          if (ty == ICMP_ECHO_REQ) begin
            side_q[i][0] = 1'b1; t_req[i] = ts;
          end else begin
            side_q[i][1] = 1'b1; t_rep[i] = ts;
          end
          r.st = ST_RECORDED;
        end
      end
      pending.push_back(r);
    endfunction

    task check_result(input logic [1:0] st, input logic [OUT_DW-1:0] d);
      echo_res_t w;
      if (pending.size() == 0) begin
        report("unexpected result", st, 0);
        return;
      end
      w = pending.pop_front();
      n_checked++;
      if (st != w.st) report("status", st, w.st);
      if (d[8:0] != w.n_req) report("request_total", d[8:0], w.n_req);
      if (d[17:9] != w.n_rep) report("reply_total", d[17:9], w.n_rep);
      if (d[26:18] != w.n_miss) report("missing_total", d[26:18], w.n_miss);
      if (d[35:27] != w.n_comp) report("complete_total", d[35:27], w.n_comp);
      if (d[36] != w.rtt_ok) report("rtt_valid", d[36], w.rtt_ok);
      if (d[85:37] != w.rtt_min) report("rtt_min_us", d[85:37], w.rtt_min);
      if (d[134:86] != w.rtt_max) report("rtt_max_us", d[134:86], w.rtt_max);
      if (d[183:135] != w.rtt_avg) report("rtt_avg_us", d[183:135], w.rtt_avg);
      if (d[197:184] != w.loss) report("loss_bp", d[197:184], w.loss);
      if (d[199:198] != 0) report("pad", d[199:198], 0);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DW-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic sent_all = 0;
  int n_sent = 0, n_sum = 0;

  echo_table_sb sb = new();

  icmp_echo_rtt_tracker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // burst_mode: no gaps on this stretch
  logic burst_mode = 0;

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic kind, input logic [7:0] ty, input logic [31:0] src,
                              input logic [31:0] dst, input logic [15:0] id,
                              input logic [15:0] sq, input logic [47:0] ts);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {ts, sq, id, dst, src, ty};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(kind, {ts, sq, id, dst, src, ty});
    n_sent++;
    if (kind) n_sum++;
    @(negedge clk);
  endtask

  task automatic send_summary();
    send_request(1, 8'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom),
                 48'({$urandom, $urandom}));
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // result side: random stalls, sampled at the rising edge
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tuser, out_tdata);
      @(negedge clk);
    end
  end

  initial begin
    logic [31:0] hosts[4];
    logic [47:0] ts;
    logic [31:0] a, b;
    logic [15:0] id, sq;
    int r;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: empty summary, extremes, ignored types, negative RTT, overwrite
    send_summary();
    send_request(0, 8'd8, '1, '1, '1, '1, '1);
    send_request(0, 8'd0, '1, '1, '1, '1, 48'd0);
    send_request(0, 8'd8, 32'd0, 32'd0, 16'd0, 16'd0, 48'd100);
    send_summary();
    send_request(0, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0, 48'd350);
    send_request(0, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0, 48'd400);
    send_request(0, 8'd1, 32'h0a000001, 32'h0a000002, 16'd1, 16'd1, 48'd5);
    send_request(0, 8'd255, 32'h0a000001, 32'h0a000002, 16'd1, 16'd1, 48'd5);
    send_request(0, 8'd0, 32'h0a000002, 32'h0a000001, 16'd7, 16'd9, 48'd10);
    send_summary();
    send_request(0, 8'd8, 32'h0a000001, 32'h0a000002, 16'd7, 16'd9, 48'd1);
    send_request(0, 8'd8, 32'h0a000001, 32'h0a000002, 16'd7, 16'd9, 48'd3);
    send_request(0, 8'd8, 32'h0a000001, 32'h0a000002, 16'h8000, 16'h8000, 48'h800000000000);
    send_summary();
    drain();

    hosts[0] = 32'hc0a80001; hosts[1] = 32'hc0a80002;
    hosts[2] = 32'h08080808; hosts[3] = $urandom;
    ts = 48'd1000;
    burst_mode = 0;
    // random: mostly matched request/reply pairs, table filling to full
    for (int k = 0; k < 410; k++) begin
      if (k == 150) drain();
      burst_mode = (k >= 200 && k < 240);
      r = $urandom_range(0, 99);
      a = hosts[$urandom_range(0, 3)];
      b = hosts[$urandom_range(0, 3)];
      id = 16'($urandom_range(0, 3));
      sq = 16'($urandom_range(0, 120));
      ts = ts + 48'($urandom_range(0, 5000));
      if (r < 8) send_summary();
      else if (r < 14) send_request(0, 8'($urandom), $urandom, $urandom, 16'($urandom),
                                    16'($urandom), 48'({$urandom, $urandom}));
      else if (r < 20) send_request(0, $urandom_range(0, 1) ? 8'd8 : 8'd0, $urandom,
                                    $urandom, 16'($urandom), 16'($urandom),
                                    48'({$urandom, $urandom}));
      else if (r < 60) begin
        send_request(0, 8'd8, a, b, id, sq, ts);
        if ($urandom_range(0, 3) != 0)
          send_request(0, 8'd0, b, a, id, sq, ts + 48'($urandom_range(0, 200000)));
        k++;
      end else if (r < 80) send_request(0, 8'd0, b, a, id, sq, ts);
      else send_request(0, 8'd8, a, b, id, sq, ts - 48'($urandom_range(0, 900)));
    end
    burst_mode = 0;
    send_summary();
    drain();
    sent_all = 1;
  end

  initial begin
    wait (sent_all);
    repeat (2000) @(posedge clk);
    $display("ran %0d requests (%0d summaries), checked %0d results, table fill %0d",
             n_sent, n_sum, sb.n_checked, sb.fill);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(20000000);
    $display("timeout");
    $display("tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
